// ===== src/sau_pkg.sv =====
// sau_pkg: types and codes shared by the stack arithmetic unit
// no dependencies

package sau_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH     = 3'd0,
    REQ_POP      = 3'd1,
    REQ_ADD      = 3'd2,
    REQ_SUB      = 3'd3,
    REQ_MUL      = 3'd4,
    REQ_DIV      = 3'd5,
    REQ_PEEK_TOP = 3'd6,
    REQ_PEEK_BOT = 3'd7
  } req_type_t;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_FULL  = 3'd1,
    ERR_EMPTY = 3'd2,
    ERR_INDEX = 3'd3,
    ERR_FEW   = 3'd4,
    ERR_DIV0  = 3'd5
  } err_code_t;

  typedef struct packed {
    req_type_t          req_type;
    logic signed [31:0] push_value;
    logic [5:0]         peek_index;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    err_code_t          error_code;
    logic [6:0]         depth;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic rd_en;
    logic start;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_iter;
    logic iter_done;
  } status_t;

endpackage

// ===== src/sau_iter.sv =====
// sau_iter: shared bit-serial multiplier and floor divider
// depends on: nothing beyond its ports

module sau_iter #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  div_mode,
  input  logic [DATA_WIDTH-1:0] opnd_s,
  input  logic [DATA_WIDTH-1:0] opnd_t,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int W    = DATA_WIDTH;
  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    x_r, x_nxt;
  logic [W-1:0]    y_r, y_nxt;
  logic [W-1:0]    z_r, z_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            div_r, div_nxt;
  logic            neg_r, neg_nxt;
  logic [W:0]      trial;
  logic [W-1:0]    q_adj;

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    cnt_nxt = cnt_r;
    div_nxt = div_r;
    neg_nxt = neg_r;
    trial   = {z_r, x_r[W-1]} - {1'b0, y_r};
    if (start) begin
      div_nxt = div_mode;
      cnt_nxt = CNTW'(W);
      z_nxt   = '0;
      neg_nxt = opnd_s[W-1] ^ opnd_t[W-1];
      if (div_mode) begin
        x_nxt = opnd_s[W-1] ? (W'(0) - opnd_s) : opnd_s;
        y_nxt = opnd_t[W-1] ? (W'(0) - opnd_t) : opnd_t;
      end else begin
        x_nxt = opnd_t;
        y_nxt = opnd_s;
      end
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNTW'(1);
      if (div_r) begin
        if (!trial[W]) begin
          z_nxt = trial[W-1:0];
          x_nxt = {x_r[W-2:0], 1'b1};
        end else begin
          z_nxt = {z_r[W-2:0], x_r[W-1]};
          x_nxt = {x_r[W-2:0], 1'b0};
        end
      end else begin
        if (x_r[0]) begin
          z_nxt = z_r + y_r;
        end
        x_nxt = {1'b0, x_r[W-1:1]};
        y_nxt = {y_r[W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    div_r <= div_nxt;
    neg_r <= neg_nxt;
  end

  assign q_adj = x_r + W'(z_r != '0);
  assign done  = (cnt_r == '0);

  always_comb begin
    if (!div_r) begin
      result = z_r;
    end else if (neg_r) begin
      result = W'(0) - q_adj;
    end else begin
      result = x_r;
    end
  end

endmodule

// ===== src/sau_dp.sv =====
// sau_dp: stack memory, depth counter, adder and result register
// depends on: sau_pkg, sau_iter

module sau_dp #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sau_pkg::in_t     in_data,
  input  sau_pkg::cmd_t    cmd,
  output sau_pkg::status_t status,
  output sau_pkg::out_t    out_data
);

  localparam int W  = DATA_WIDTH;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (CW > 6) ? CW : 6;

  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  rd_a_r;
  logic [W-1:0]  rd_b_r;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  logic [IW-1:0] cnt_iw;
  logic [IW-1:0] idx_iw;

  sau_pkg::in_t  req_r;
  sau_pkg::out_t out_r, out_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic [W-1:0]  val;
  logic [W-1:0]  pv_ext;
  logic [W-1:0]  iter_res;
  logic          iter_done;
  logic          two_ok;
  logic          div_req;

  assign cnt_iw = IW'(count_r);
  assign idx_iw = IW'(in_data.peek_index);

  always_comb begin
    case (in_data.req_type)
      sau_pkg::REQ_PEEK_TOP: addr_a = AW'(cnt_iw - IW'(1) - idx_iw);
      sau_pkg::REQ_PEEK_BOT: addr_a = AW'(idx_iw);
      default:               addr_a = AW'(count_r - CW'(1));
    endcase
  end
  assign addr_b = AW'(count_r - CW'(2));

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_a_r <= mem[addr_a];
      rd_b_r <= mem[addr_b];
      req_r  <= in_data;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign two_ok  = (count_r >= CW'(2));
  assign div_req = (req_r.req_type == sau_pkg::REQ_DIV);
  assign pv_ext  = W'(64'(req_r.push_value));

  sau_iter #(
    .DATA_WIDTH(W)
  ) u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.start),
    .div_mode(div_req),
    .opnd_s  (rd_b_r),
    .opnd_t  (rd_a_r),
    .done    (iter_done),
    .result  (iter_res)
  );

  assign status.iter_done = iter_done;
  assign status.need_iter = two_ok && ((req_r.req_type == sau_pkg::REQ_MUL) ||
                            (div_req && (rd_a_r != '0)));

  always_comb begin
    sau_pkg::err_code_t err;
    err       = sau_pkg::ERR_OK;
    val       = '0;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = AW'(count_r - CW'(2));
    wr_data   = '0;
    case (req_r.req_type)
      sau_pkg::REQ_PUSH: begin
        if (count_r >= CW'(STACK_DEPTH)) begin
          err = sau_pkg::ERR_FULL;
        end else begin
          val       = pv_ext;
          wr_addr   = AW'(count_r);
          wr_data   = pv_ext;
          wr_en     = cmd.commit;
          count_nxt = count_r + CW'(1);
        end
      end
      sau_pkg::REQ_POP: begin
        if (count_r == '0) begin
          err = sau_pkg::ERR_EMPTY;
        end else begin
          val       = rd_a_r;
          count_nxt = count_r - CW'(1);
        end
      end
      sau_pkg::REQ_ADD, sau_pkg::REQ_SUB, sau_pkg::REQ_MUL, sau_pkg::REQ_DIV: begin
        if (!two_ok) begin
          err = sau_pkg::ERR_FEW;
        end else if (div_req && (rd_a_r == '0)) begin
          err       = sau_pkg::ERR_DIV0;
          count_nxt = count_r - CW'(2);
        end else begin
          case (req_r.req_type)
            sau_pkg::REQ_ADD: val = rd_b_r + rd_a_r;
            sau_pkg::REQ_SUB: val = rd_b_r - rd_a_r;
            default:          val = iter_res;
          endcase
          wr_data   = val;
          wr_en     = cmd.commit;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        if (IW'(req_r.peek_index) >= cnt_iw) begin
          err = sau_pkg::ERR_INDEX;
        end else begin
          val = rd_a_r;
        end
      end
    endcase
    out_nxt.result_value = 32'(64'($signed(val)));
    out_nxt.error_code   = err;
    out_nxt.depth        = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// ===== src/sau_ctrl.sv =====
// sau_ctrl: request sequencer and output valid register
// depends on: sau_pkg

module sau_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  sau_pkg::status_t status,
  output sau_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    cmd.rd_en  = 1'b0;
    cmd.start  = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.rd_en = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.need_iter) begin
          cmd.start = 1'b1;
          state_nxt = ST_ITER;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_ITER: begin
        if (status.iter_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/stack_arithmetic_unit_top.sv =====
// stack_arithmetic_unit_top: bounded integer evaluation stack
// (push, pop, add, sub, mul, floor div, peeks). input channel carries one
// request per transaction, output channel one result per request.
// channels use valid/stall; a transaction moves when valid is high and
// stall is low. the block takes one request at a time.
// push, pop, add, sub, peeks and divide by zero: the accept edge reads
// both stack operands from the memory into registers; the write-back and
// the result register load follow once the result register is free.
// mul and div with two operands also pass through the shared bit-serial
// unit, which retires one bit per cycle, before write-back.
// the result register holds the last result while out_stall is high; a
// new request may be accepted meanwhile, but its result waits until the
// register is free, and in_stall stays high until then.
// synchronous reset empties the stack and drops any pending result;
// stack contents are not cleared and need no clearing pass.
// depends on: sau_pkg, sau_ctrl, sau_dp, sau_iter

module stack_arithmetic_unit_top #(
  parameter int STACK_DEPTH = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  sau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output sau_pkg::out_t out_data
);

  sau_pkg::cmd_t    cmd;
  sau_pkg::status_t status;

  sau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sau_dp #(
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .status  (status),
    .out_data(out_data)
  );

endmodule
